@@ sv/ray_box_slab_test_macros.svh @@
// ----------------------------------------------------------------------------
// Ray box slab test assertion macros
// Concurrent assertion helpers that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef RAY_BOX_SLAB_TEST_MACROS_SVH
`define RAY_BOX_SLAB_TEST_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication checked on every rising edge outside reset.
`define RBST_ASSERT_NOW(lbl, clk, rst, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
// Next-cycle implication checked on every rising edge outside reset.
`define RBST_ASSERT_NEXT(lbl, clk, rst, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`else
`define RBST_ASSERT_NOW(lbl, clk, rst, a, b, msg)
`define RBST_ASSERT_NEXT(lbl, clk, rst, a, b, msg)
`endif
`endif

@@ sv/rbst_pkg.sv @@
// ----------------------------------------------------------------------------
// Ray box slab test package
// Lane counts, register width and the side-band record of the pipeline.
// ----------------------------------------------------------------------------
package rbst_pkg;
  localparam int AXES      = 3;
  localparam int LANES     = 2 * AXES;
  localparam int THR_WIDTH = 16;

  // Per-item control that rides alongside the divider lanes.
  typedef struct packed {
    logic [LANES-1:0] neg;
    logic [AXES-1:0]  par;
    logic             miss;
  } meta_t;
endpackage

@@ sv/rbst_ray_if.sv @@
// ----------------------------------------------------------------------------
// Ray box channel
// Carries one ray and one box per word with valid and ready.
// ----------------------------------------------------------------------------
interface rbst_ray_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] origin_x;
  logic signed [COORD_WIDTH-1:0] origin_y;
  logic signed [COORD_WIDTH-1:0] origin_z;
  logic signed [COORD_WIDTH-1:0] direction_x;
  logic signed [COORD_WIDTH-1:0] direction_y;
  logic signed [COORD_WIDTH-1:0] direction_z;
  logic signed [COORD_WIDTH-1:0] box_min_x;
  logic signed [COORD_WIDTH-1:0] box_min_y;
  logic signed [COORD_WIDTH-1:0] box_min_z;
  logic signed [COORD_WIDTH-1:0] box_max_x;
  logic signed [COORD_WIDTH-1:0] box_max_y;
  logic signed [COORD_WIDTH-1:0] box_max_z;

  modport source (output valid, origin_x, origin_y, origin_z, direction_x, direction_y,
                  direction_z, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                  box_max_z, input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, direction_x, direction_y,
                direction_z, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                box_max_z, output ready);
endinterface

@@ sv/rbst_hit_if.sv @@
// ----------------------------------------------------------------------------
// Hit result channel
// Carries one hit flag per word with valid and ready.
// ----------------------------------------------------------------------------
interface rbst_hit_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

@@ sv/rbst_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries the parallel threshold write data with valid and ready.
// ----------------------------------------------------------------------------
interface rbst_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rbst_pkg::THR_WIDTH-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ sv/ray_box_slab_test.sv @@
// ----------------------------------------------------------------------------
// Ray box slab test
// Pipelined ray against axis-aligned box intersection in signed fixed point.
// ----------------------------------------------------------------------------
// One ray and box word is taken every clock unless the output stalls, and one
// hit word comes out for each, in order, after the setup register, the divider
// chain and the reduction registers (Q16.16 by default). The six slab dividers
// produce one quotient bit per pipeline stage. The whole pipeline advances
// whenever the output register is empty or being read, so a stalled result
// holds every stage. The parallel threshold register resets to 1 and may be
// written while the block is idle; its channel is always ready.
module ray_box_slab_test #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic clk,
  input  logic rst,
  rbst_cfg_if.sink                 cfg,
  rbst_ray_if.sink                 ray,
  rbst_hit_if.source               result
);
  `include "ray_box_slab_test_macros.svh"

  localparam int W = COORD_WIDTH;
  localparam int S = COORD_WIDTH + FRAC_BITS;
  localparam int L = rbst_pkg::LANES;
  localparam int A = rbst_pkg::AXES;

  logic [rbst_pkg::THR_WIDTH-1:0] thr;
  logic                           en;
  logic [S:0]                     vld;
  rbst_pkg::meta_t                metac [0:S];
  logic [A-1:0][W-1:0]            dmc   [0:S];
  logic [L-1:0][W-1:0]            numc  [0:S];
  logic [L-1:0][W-2:0]            remc  [0:S];
  logic [L-1:0][W-2:0]            qc    [0:S];
  logic [L-1:0]                   satc  [0:S];

  // Threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= rbst_pkg::THR_WIDTH'(1);
    end else if (cfg.valid) begin
      thr <= cfg.data;
    end
  end
  assign cfg.ready = 1'b1;

  // Global advance: the output register is free or being drained.
  assign en        = !result.valid || result.ready;
  assign ray.ready = en;

  // Setup stage.
  rbst_prep #(.COORD_WIDTH(W)) u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (ray.valid),
    .thr       (thr),
    .org       ({ray.origin_z, ray.origin_y, ray.origin_x}),
    .dir       ({ray.direction_z, ray.direction_y, ray.direction_x}),
    .lo        ({ray.box_min_z, ray.box_min_y, ray.box_min_x}),
    .hi        ({ray.box_max_z, ray.box_max_y, ray.box_max_x}),
    .valid_out (vld[0]),
    .meta      (metac[0]),
    .dm        (dmc[0]),
    .num       (numc[0])
  );
  assign remc[0] = '0;
  assign qc[0]   = '0;
  assign satc[0] = '0;

  // Divider chain, one quotient bit per stage.
  for (genvar k = 0; k < S; k++) begin : g_div
    rbst_div_step #(.COORD_WIDTH(W)) u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .valid_in  (vld[k]),
      .meta_in   (metac[k]),
      .dm_in     (dmc[k]),
      .num_in    (numc[k]),
      .rem_in    (remc[k]),
      .q_in      (qc[k]),
      .sat_in    (satc[k]),
      .valid_out (vld[k+1]),
      .meta_out  (metac[k+1]),
      .dm_out    (dmc[k+1]),
      .num_out   (numc[k+1]),
      .rem_out   (remc[k+1]),
      .q_out     (qc[k+1]),
      .sat_out   (satc[k+1])
    );
  end

  // Sign, reduce and compare.
  rbst_reduce #(.COORD_WIDTH(W)) u_reduce (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (vld[S]),
    .meta_in   (metac[S]),
    .q_in      (qc[S]),
    .sat_in    (satc[S]),
    .valid_out (result.valid),
    .hit       (result.hit)
  );

  // Checks on the pipeline control.
  `RBST_ASSERT_NOW(a_stall_src, clk, rst, !ray.ready, result.valid, "stall without a held result")
  `RBST_ASSERT_NEXT(a_bubble, clk, rst, en && !vld[0], !vld[1], "bubble lost in divider chain")
  `RBST_ASSERT_NEXT(a_freeze, clk, rst, !en, $stable(vld), "pipeline moved while stalled")
  `RBST_ASSERT_NOW(a_cfg_rdy, clk, rst, cfg.valid, cfg.ready, "threshold write refused")
endmodule

@@ sv/rbst_prep.sv @@
// ----------------------------------------------------------------------------
// Slab setup stage
// Forms direction magnitudes, slab numerators, signs and parallel flags.
// ----------------------------------------------------------------------------
module rbst_prep #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                               clk,
  input  logic                                               rst,
  input  logic                                               en,
  input  logic                                               valid_in,
  input  logic [rbst_pkg::THR_WIDTH-1:0]                     thr,
  input  logic [rbst_pkg::AXES-1:0][COORD_WIDTH-1:0]         org,
  input  logic [rbst_pkg::AXES-1:0][COORD_WIDTH-1:0]         dir,
  input  logic [rbst_pkg::AXES-1:0][COORD_WIDTH-1:0]         lo,
  input  logic [rbst_pkg::AXES-1:0][COORD_WIDTH-1:0]         hi,
  output logic                                               valid_out,
  output rbst_pkg::meta_t                                    meta,
  output logic [rbst_pkg::AXES-1:0][COORD_WIDTH-1:0]         dm,
  output logic [rbst_pkg::LANES-1:0][COORD_WIDTH-1:0]        num
);
  localparam int W = COORD_WIDTH;

  rbst_pkg::meta_t                               meta_next;
  logic [rbst_pkg::AXES-1:0][W-1:0]              dm_next;
  logic [rbst_pkg::LANES-1:0][W-1:0]             num_next;

  // Per axis: magnitude of the direction, parallel test, swapped bounds.
  always_comb begin
    logic        dneg;
    logic [W:0]  dlo;
    logic [W:0]  dhi;
    logic [W:0]  nlo;
    logic [W:0]  nhi;
    meta_next = '0;
    dm_next   = '0;
    num_next  = '0;
    for (int a = 0; a < rbst_pkg::AXES; a++) begin
      dneg       = dir[a][W-1];
      dm_next[a] = dneg ? (~dir[a] + W'(1)) : dir[a];
      meta_next.par[a] = (dm_next[a] == '0) || (dm_next[a] < W'(thr));
      if (meta_next.par[a] &&
          (($signed(org[a]) < $signed(lo[a])) || ($signed(hi[a]) < $signed(org[a])))) begin
        meta_next.miss = 1'b1;
      end
      dlo = {lo[a][W-1], lo[a]} - {org[a][W-1], org[a]};
      dhi = {hi[a][W-1], hi[a]} - {org[a][W-1], org[a]};
      nlo = dlo[W] ? (~dlo + (W+1)'(1)) : dlo;
      nhi = dhi[W] ? (~dhi + (W+1)'(1)) : dhi;
      if (dneg) begin
        num_next[2*a]       = nhi[W-1:0];
        num_next[2*a+1]     = nlo[W-1:0];
        meta_next.neg[2*a]  = dhi[W] ^ dneg;
        meta_next.neg[2*a+1] = dlo[W] ^ dneg;
      end else begin
        num_next[2*a]       = nlo[W-1:0];
        num_next[2*a+1]     = nhi[W-1:0];
        meta_next.neg[2*a]  = dlo[W] ^ dneg;
        meta_next.neg[2*a+1] = dhi[W] ^ dneg;
      end
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
    if (en) begin
      meta <= meta_next;
      dm   <= dm_next;
      num  <= num_next;
    end
  end
endmodule

@@ sv/rbst_div_step.sv @@
// ----------------------------------------------------------------------------
// Divider step stage
// One restoring quotient bit for all six slab lanes, with saturation.
// ----------------------------------------------------------------------------
module rbst_div_step #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          en,
  input  logic                                          valid_in,
  input  rbst_pkg::meta_t                               meta_in,
  input  logic [rbst_pkg::AXES-1:0][COORD_WIDTH-1:0]    dm_in,
  input  logic [rbst_pkg::LANES-1:0][COORD_WIDTH-1:0]   num_in,
  input  logic [rbst_pkg::LANES-1:0][COORD_WIDTH-2:0]   rem_in,
  input  logic [rbst_pkg::LANES-1:0][COORD_WIDTH-2:0]   q_in,
  input  logic [rbst_pkg::LANES-1:0]                    sat_in,
  output logic                                          valid_out,
  output rbst_pkg::meta_t                               meta_out,
  output logic [rbst_pkg::AXES-1:0][COORD_WIDTH-1:0]    dm_out,
  output logic [rbst_pkg::LANES-1:0][COORD_WIDTH-1:0]   num_out,
  output logic [rbst_pkg::LANES-1:0][COORD_WIDTH-2:0]   rem_out,
  output logic [rbst_pkg::LANES-1:0][COORD_WIDTH-2:0]   q_out,
  output logic [rbst_pkg::LANES-1:0]                    sat_out
);
  localparam int W = COORD_WIDTH;

  logic [rbst_pkg::LANES-1:0][W-1:0] num_next;
  logic [rbst_pkg::LANES-1:0][W-2:0] rem_next;
  logic [rbst_pkg::LANES-1:0][W-2:0] q_next;
  logic [rbst_pkg::LANES-1:0]        sat_next;

  // Shift in the next dividend bit, trial subtract, append the quotient bit.
  // The remainder stays below the divisor, so it always fits in W-1 bits.
  always_comb begin
    logic [W-1:0] r2;
    logic [W-1:0] dv;
    logic [W-1:0] qw;
    logic         ge;
    for (int l = 0; l < rbst_pkg::LANES; l++) begin
      dv          = dm_in[l/2];
      r2          = {rem_in[l], num_in[l][W-1]};
      ge          = (r2 >= dv);
      rem_next[l] = ge ? (W-1)'(r2 - dv) : r2[W-2:0];
      num_next[l] = {num_in[l][W-2:0], 1'b0};
      qw          = {q_in[l], ge};
      if (sat_in[l]) begin
        sat_next[l] = 1'b1;
        q_next[l]   = q_in[l];
      end else begin
        sat_next[l] = qw[W-1];
        q_next[l]   = qw[W-2:0];
      end
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
    if (en) begin
      meta_out <= meta_in;
      dm_out   <= dm_in;
      num_out  <= num_next;
      rem_out  <= rem_next;
      q_out    <= q_next;
      sat_out  <= sat_next;
    end
  end
endmodule

@@ sv/rbst_reduce.sv @@
// ----------------------------------------------------------------------------
// Slab reduction stages
// Signs the slab parameters, then takes the largest entry and smallest exit.
// ----------------------------------------------------------------------------
module rbst_reduce #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          en,
  input  logic                                          valid_in,
  input  rbst_pkg::meta_t                               meta_in,
  input  logic [rbst_pkg::LANES-1:0][COORD_WIDTH-2:0]   q_in,
  input  logic [rbst_pkg::LANES-1:0]                    sat_in,
  output logic                                          valid_out,
  output logic                                          hit
);
  localparam int W = COORD_WIDTH;
  localparam logic [W-1:0] TMAX = {1'b0, {(W-1){1'b1}}};

  logic [rbst_pkg::LANES-1:0][W-1:0] t_next;
  logic [rbst_pkg::LANES-1:0][W-1:0] t;
  rbst_pkg::meta_t                   meta;
  logic                              valid_mid;
  logic                              hit_next;

  // Saturate to the largest magnitude and apply the quotient sign.
  always_comb begin
    logic [W-1:0] mag;
    for (int l = 0; l < rbst_pkg::LANES; l++) begin
      mag       = sat_in[l] ? TMAX : {1'b0, q_in[l]};
      t_next[l] = meta_in.neg[l] ? (~mag + W'(1)) : mag;
    end
  end

  // Largest entry against smallest exit; parallel axes leave the bounds open.
  always_comb begin
    logic [W-1:0] t0;
    logic [W-1:0] t1;
    t0 = ~TMAX + W'(1);
    t1 = TMAX;
    for (int a = 0; a < rbst_pkg::AXES; a++) begin
      if (!meta.par[a]) begin
        if ($signed(t[2*a]) > $signed(t0)) begin
          t0 = t[2*a];
        end
        if ($signed(t[2*a+1]) < $signed(t1)) begin
          t1 = t[2*a+1];
        end
      end
    end
    hit_next = !meta.miss && ($signed(t0) < $signed(t1));
  end

  // Two stage registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_mid <= 1'b0;
      valid_out <= 1'b0;
    end else if (en) begin
      valid_mid <= valid_in;
      valid_out <= valid_mid;
    end
    if (en) begin
      t    <= t_next;
      meta <= meta_in;
      hit  <= hit_next;
    end
  end
endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ray box slab test bench
// Streams rays and boxes through the intersection pipeline and checks every
// hit word against an in-bench slab predictor under several thresholds.
// ----------------------------------------------------------------------------
module tb;
  localparam int CW       = 32;
  localparam int FB       = 16;
  localparam int LATENCY  = CW + FB + 3;
  localparam longint TMAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam int LIMIT    = 400000;

  typedef struct {
    logic signed [CW-1:0] org [3];
    logic signed [CW-1:0] dir [3];
    logic signed [CW-1:0] lo [3];
    logic signed [CW-1:0] hi [3];
  } ray_box_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rbst_cfg_if          cfg ();
  rbst_ray_if #(.COORD_WIDTH(CW)) ray ();
  rbst_hit_if          result ();

  ray_box_slab_test #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg.sink),
    .ray    (ray.sink),
    .result (result.source)
  );

  // Predictor state and scoreboard.
  logic [rbst_pkg::THR_WIDTH-1:0] threshold;
  logic                 hits_due [$];
  int                   mismatches = 0;
  int                   words_seen = 0;
  int                   hits_seen = 0;
  int                   cycles = 0;
  int                   hold_off = 0;
  bit                   long_stall = 1'b0;

  // Clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Saturated truncated quotient ((bound - org) << FB) / dir.
  function automatic longint slab_quotient(longint bound, longint org, longint dir);
    logic signed [127:0] num;
    logic signed [127:0] q;
    num = (128'(signed'(bound)) - 128'(signed'(org))) <<< FB;
    q = num / 128'(signed'(dir));
    if (q > TMAX) return TMAX;
    if (q < -TMAX) return -TMAX;
    return longint'(q);
  endfunction

  function automatic logic predict_hit(ray_box_t rb);
    longint t_enter;
    longint t_exit;
    longint o, d, l, h, mag, te, tx;
    logic   missed;
    t_enter = -TMAX;
    t_exit = TMAX;
    missed = 1'b0;
    for (int a = 0; a < 3; a++) begin
      o = rb.org[a];
      d = rb.dir[a];
      l = rb.lo[a];
      h = rb.hi[a];
      mag = (d < 0) ? -d : d;
      if (mag == 0 || mag < longint'(threshold)) begin
        // Parallel axis: only the origin's position in the slab matters.
        if (o < l || o > h) missed = 1'b1;
      end else begin
        te = slab_quotient((d < 0) ? h : l, o, d);
        tx = slab_quotient((d < 0) ? l : h, o, d);
        if (te > t_enter) t_enter = te;
        if (tx < t_exit) t_exit = tx;
      end
    end
    return !missed && (t_enter < t_exit);
  endfunction

  function automatic int short_or_long_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side: ready with random gaps, long hold-off on request.
  initial begin
    result.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        result.ready <= 1'b0;
        hold_off = hold_off - 1;
      end else if (long_stall || $urandom_range(0, 3) != 0) begin
        result.ready <= 1'b1;
      end else begin
        result.ready <= 1'b0;
      end
      if (!long_stall && $urandom_range(0, 99) == 0) hold_off = short_or_long_gap();
    end
  end

  // Check each hit word against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && result.valid && result.ready) begin
      words_seen++;
      if (result.hit) hits_seen++;
      if (hits_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("tb: unexpected hit word %0b", result.hit);
      end else begin
        logic want;
        want = hits_due.pop_front();
        if (result.hit !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb: hit mismatch, expected %0b got %0b", want, result.hit);
        end
      end
    end
  end

  // Valid stays high after acceptance; the next call or drain() decides
  // whether it drops, so each falling edge sees one update of it.
  task automatic send_ray(ray_box_t rb, bit allow_gap = 1'b1);
    int gap;
    gap = allow_gap ? short_or_long_gap() : 0;
    repeat (gap) begin
      ray.valid <= 1'b0;
      @(negedge clk);
    end
    ray.valid       <= 1'b1;
    ray.origin_x    <= rb.org[0];
    ray.origin_y    <= rb.org[1];
    ray.origin_z    <= rb.org[2];
    ray.direction_x <= rb.dir[0];
    ray.direction_y <= rb.dir[1];
    ray.direction_z <= rb.dir[2];
    ray.box_min_x   <= rb.lo[0];
    ray.box_min_y   <= rb.lo[1];
    ray.box_min_z   <= rb.lo[2];
    ray.box_max_x   <= rb.hi[0];
    ray.box_max_y   <= rb.hi[1];
    ray.box_max_z   <= rb.hi[2];
    do @(posedge clk); while (!ray.ready);
    hits_due.push_back(predict_hit(rb));
    @(negedge clk);
  endtask

  task automatic drain();
    ray.valid <= 1'b0;
    while (hits_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_threshold(logic [rbst_pkg::THR_WIDTH-1:0] value);
    cfg.valid <= 1'b1;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    threshold = value;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  function automatic logic signed [CW-1:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h0014_0000)) - 32'sh000A_0000;
      2: return $signed($urandom_range(0, 8)) - 4;
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 0;
          default: return $urandom();
        endcase
      end
    endcase
  endfunction

  // A box around a point with a ray aimed near it, or raw noise.
  function automatic ray_box_t random_ray_box();
    ray_box_t rb;
    int mode;
    logic signed [CW-1:0] c, ext;
    mode = $urandom_range(0, 9);
    for (int a = 0; a < 3; a++) begin
      if (mode < 2) begin
        rb.org[a] = rand_coord(mode == 0 ? 0 : 3);
        rb.dir[a] = rand_coord($urandom_range(0, 3));
        rb.lo[a]  = rand_coord(0);
        rb.hi[a]  = rand_coord(0);
      end else begin
        c = rand_coord(1);
        ext = $urandom_range(0, 32'h0004_0000);
        rb.lo[a] = c - ext;
        rb.hi[a] = c + ext;
        rb.org[a] = rand_coord(1);
        rb.dir[a] = ($urandom_range(0, 5) == 0) ? rand_coord(2) : (c - rb.org[a]);
        if ($urandom_range(0, 7) == 0) rb.dir[a] = -rb.dir[a];
      end
    end
    return rb;
  endfunction

  function automatic ray_box_t make_ray_box(logic signed [CW-1:0] o, d, l, h);
    ray_box_t rb;
    for (int a = 0; a < 3; a++) begin
      rb.org[a] = o;
      rb.dir[a] = d;
      rb.lo[a] = l;
      rb.hi[a] = h;
    end
    return rb;
  endfunction

  // Extremes, parallel axes, negative directions and inverted boxes.
  task automatic test_directed();
    ray_box_t rb;
    send_ray(make_ray_box(0, 32'sh0001_0000, 32'sh0001_0000, 32'sh0002_0000));
    send_ray(make_ray_box(0, -32'sh0001_0000, 32'sh0001_0000, 32'sh0002_0000));
    send_ray(make_ray_box(0, 0, -32'sh0001_0000, 32'sh0001_0000));
    send_ray(make_ray_box(32'sh0003_0000, 0, -32'sh0001_0000, 32'sh0001_0000));
    send_ray(make_ray_box(32'sh0001_0000, 0, -32'sh0001_0000, 32'sh0001_0000));
    send_ray(make_ray_box(0, 32'sh0001_0000, 32'sh0002_0000, -32'sh0002_0000));
    send_ray(make_ray_box(32'sh8000_0000, 1, 32'sh8000_0000, 32'sh7FFF_FFFF));
    send_ray(make_ray_box(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF));
    send_ray(make_ray_box(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    send_ray(make_ray_box(0, -1, 32'sh8000_0000, 32'sh8000_0000));
    send_ray(make_ray_box(32'sh0005_0000, 32'sh0001_0000, 0, 32'sh0001_0000));
    send_ray(make_ray_box(-1, -1, -1, -1));
    rb = make_ray_box(0, 0, -32'sh0001_0000, 32'sh0001_0000);
    rb.dir[1] = 32'sh0000_8000;
    rb.lo[1] = 32'sh0001_0000;
    rb.hi[1] = 32'sh0001_0000;
    send_ray(rb);
    rb.dir[2] = -32'sh0000_0100;
    send_ray(rb);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_ray(random_ray_box());
  endtask

  // Back-to-back input while the receiver holds off, to fill the pipeline.
  task automatic test_backpressure();
    long_stall = 1'b1;
    hold_off = 3 * LATENCY;
    for (int i = 0; i < 120; i++) send_ray(random_ray_box(), 1'b0);
    long_stall = 1'b0;
  endtask

  initial begin
    cfg.valid = 1'b0;
    cfg.data = '0;
    ray.valid = 1'b0;
    {ray.origin_x, ray.origin_y, ray.origin_z} = '0;
    {ray.direction_x, ray.direction_y, ray.direction_z} = '0;
    {ray.box_min_x, ray.box_min_y, ray.box_min_z} = '0;
    {ray.box_max_x, ray.box_max_y, ray.box_max_z} = '0;
    threshold = 1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_random(250);
    drain();
    write_threshold(0);
    test_directed();
    test_random(150);
    drain();
    write_threshold(16'hFFFF);
    test_directed();
    test_random(150);
    drain();
    write_threshold(16'h0042);
    test_backpressure();
    test_random(200);
    drain();

    $display("tb: %0d hit words checked (%0d hits) over thresholds 1, 0, max and mid",
             words_seen, hits_seen);
    $display("tb: covered parallel slabs, saturation extremes and a full-pipeline stall");
    if (mismatches == 0 && hits_due.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
